// ===== rtl/ctsim_pkg.sv =====
// shared constants, types and helpers for the chunk to shard index map
package ctsim_pkg;

  localparam int DATA_W     = 32;
  localparam int DIM_W      = 16;
  localparam int SIDE_W     = 2 * DATA_W;
  localparam int DIV_STAGES = DATA_W;
  localparam int ADDR_W     = 5;

  // register indexes
  localparam logic [2:0] REG_CHUNKS_DIM1 = 3'd0;
  localparam logic [2:0] REG_CHUNKS_DIM2 = 3'd1;
  localparam logic [2:0] REG_CHUNKS_DIM3 = 3'd2;
  localparam logic [2:0] REG_SHARD_DIM0  = 3'd3;
  localparam logic [2:0] REG_SHARD_DIM1  = 3'd4;
  localparam logic [2:0] REG_SHARD_DIM2  = 3'd5;
  localparam logic [2:0] REG_SHARD_DIM3  = 3'd6;

  typedef logic [DATA_W-1:0] word_t;
  typedef logic [DIM_W-1:0]  dim_t;

  function automatic word_t mul_lo(word_t a, word_t b);
    logic [2*DATA_W-1:0] p;
    p = a * b;
    return p[DATA_W-1:0];
  endfunction

endpackage

// ===== rtl/ctsim_div.sv =====
// pipelined restoring divider, one quotient bit per stage, with sideband
module ctsim_div import ctsim_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  word_t               dividend,
  input  logic [DATA_W:0]     divisor,
  input  logic [SIDE_W-1:0]   side_in,
  output logic                out_valid,
  output word_t               quot,
  output word_t               rem,
  output logic [SIDE_W-1:0]   side_out
);

  logic              vld    [DIV_STAGES];
  word_t             rem_q  [DIV_STAGES];
  word_t             num_q  [DIV_STAGES];
  logic [SIDE_W-1:0] side_q [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    word_t             rem_in;
    word_t             num_in;
    logic [SIDE_W-1:0] side_k;
    logic              vld_in;
    logic [DATA_W:0]   trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = dividend;
      assign side_k = side_in;
      assign vld_in = in_valid;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign num_in = num_q[k-1];
      assign side_k = side_q[k-1];
      assign vld_in = vld[k-1];
    end

    // quotient bits shift into the low end as dividend bits leave the top
    assign trial = {rem_in, num_in[DATA_W-1]};
    assign ge    = (trial >= divisor);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld_in;
      end
      if (en) begin
        rem_q[k]  <= ge ? word_t'(trial - divisor) : trial[DATA_W-1:0];
        num_q[k]  <= {num_in[DATA_W-2:0], ge};
        side_q[k] <= side_k;
      end
    end
  end

  assign out_valid = vld[DIV_STAGES-1];
  assign quot      = num_q[DIV_STAGES-1];
  assign rem       = rem_q[DIV_STAGES-1];
  assign side_out  = side_q[DIV_STAGES-1];

endmodule

// ===== rtl/chunk_to_shard_index_map.sv =====
// top level: chunk index to shard number and slot in shard, 4 dimensions
// One chunk_number request is accepted per cycle while s_tready is high;
// its shard_number and slot_in_shard pass through four chained 32-stage divider
// pipelines (coordinate split by chunk strides, then the split by shard
// lengths) plus one multiply stage and one add stage. The whole pipeline
// stalls together when the result is not taken. After reset and after every
// register write, s_tready stays low while strides and shard counts are
// recomputed by a small sequencer with a 17-step divider.
// A write of zero leaves a register unchanged.
module chunk_to_shard_index_map import ctsim_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [31:0]       s_tdata,   // chunk_number
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [63:0]       m_tdata,   // slot_in_shard (high), shard_number (low)
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam logic [4:0] STEP_LOAD  = 5'd0;
  localparam logic [4:0] STEP_PROD  = 5'd1;
  localparam logic [4:0] STEP_SS1   = 5'd18;
  localparam logic [4:0] STEP_SS0   = 5'd19;

  // configuration registers
  dim_t chunks [3];   // dims one to three
  dim_t slen   [4];   // dims zero to three

  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) chunks[i] <= dim_t'(1);
      for (int i = 0; i < 4; i++) slen[i]   <= dim_t'(1);
    end else if (cfg_wr && (pwdata[DIM_W-1:0] != '0)) begin
      unique case (cfg_idx)
        REG_CHUNKS_DIM1: chunks[0] <= pwdata[DIM_W-1:0];
        REG_CHUNKS_DIM2: chunks[1] <= pwdata[DIM_W-1:0];
        REG_CHUNKS_DIM3: chunks[2] <= pwdata[DIM_W-1:0];
        REG_SHARD_DIM0:  slen[0]   <= pwdata[DIM_W-1:0];
        REG_SHARD_DIM1:  slen[1]   <= pwdata[DIM_W-1:0];
        REG_SHARD_DIM2:  slen[2]   <= pwdata[DIM_W-1:0];
        REG_SHARD_DIM3:  slen[3]   <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_CHUNKS_DIM1: prdata = 32'(chunks[0]);
      REG_CHUNKS_DIM2: prdata = 32'(chunks[1]);
      REG_CHUNKS_DIM3: prdata = 32'(chunks[2]);
      REG_SHARD_DIM0:  prdata = 32'(slen[0]);
      REG_SHARD_DIM1:  prdata = 32'(slen[1]);
      REG_SHARD_DIM2:  prdata = 32'(slen[2]);
      REG_SHARD_DIM3:  prdata = 32'(slen[3]);
      default:         prdata = '0;
    endcase
  end

  // derived strides, recomputed after every write
  logic            busy;
  logic [4:0]      cnt;
  word_t           cs1, is1, is0, ss1, ss0;
  logic [DATA_W:0] cs0;
  logic [16:0]     cd_num [3];
  logic [16:0]     cd_q   [3];
  dim_t            cd_rem [3];
  logic [47:0]     cs0_full;

  assign cs0_full = cs1 * chunks[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      cnt  <= STEP_LOAD;
    end else if (cfg_wr) begin
      busy <= 1'b1;
      cnt  <= STEP_LOAD;
    end else if (busy) begin
      cnt <= cnt + 5'd1;
      if (cnt == STEP_SS0) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      if (cnt == STEP_LOAD) begin
        cs1 <= word_t'(chunks[1]) * word_t'(chunks[2]);
        is1 <= word_t'(slen[2]) * word_t'(slen[3]);
        for (int i = 0; i < 3; i++) begin
          // ceiling quotient numerator
          cd_num[i] <= 17'(chunks[i]) + 17'(slen[i+1]) - 17'd1;
          cd_q[i]   <= '0;
          cd_rem[i] <= '0;
        end
      end else if (cnt <= STEP_SS1 - 5'd1) begin
        if (cnt == STEP_PROD) begin
          cs0 <= (|cs0_full[47:32]) ? {1'b1, 32'b0} : {1'b0, cs0_full[31:0]};
          is0 <= mul_lo(is1, word_t'(slen[1]));
        end
        for (int i = 0; i < 3; i++) begin
          logic [16:0] trial;
          trial = {cd_rem[i], cd_num[i][16]};
          cd_num[i] <= {cd_num[i][15:0], 1'b0};
          if (trial >= 17'(slen[i+1])) begin
            cd_rem[i] <= dim_t'(trial - 17'(slen[i+1]));
            cd_q[i]   <= {cd_q[i][15:0], 1'b1};
          end else begin
            cd_rem[i] <= trial[DIM_W-1:0];
            cd_q[i]   <= {cd_q[i][15:0], 1'b0};
          end
        end
      end else if (cnt == STEP_SS1) begin
        ss1 <= word_t'(cd_q[1][15:0]) * word_t'(cd_q[2][15:0]);
      end else begin
        ss0 <= mul_lo(ss1, word_t'(cd_q[0][15:0]));
      end
    end
  end

  // main pipeline
  logic  en;
  logic  out_valid;
  assign en       = !out_valid || m_tready;
  assign s_tready = en && !busy;

  logic              v0, v1, v2;
  logic              v3 [4];
  word_t             coord0, r0, coord1, r1, coord2, coord3;
  logic [SIDE_W-1:0] side0, side1, side2;
  word_t             coord [4];
  word_t             q [4];
  word_t             rm [4];
  logic [SIDE_W-1:0] side3 [4];

  ctsim_div u_div0 (
    .clk, .rst, .en,
    .in_valid (s_tvalid && s_tready),
    .dividend (s_tdata),
    .divisor  (cs0),
    .side_in  ('0),
    .out_valid(v0), .quot(coord0), .rem(r0), .side_out(side0)
  );

  ctsim_div u_div1 (
    .clk, .rst, .en,
    .in_valid (v0),
    .dividend (r0),
    .divisor  ({1'b0, cs1}),
    .side_in  ({side0[SIDE_W-1:DATA_W], coord0}),
    .out_valid(v1), .quot(coord1), .rem(r1), .side_out(side1)
  );

  ctsim_div u_div2 (
    .clk, .rst, .en,
    .in_valid (v1),
    .dividend (r1),
    .divisor  ((DATA_W+1)'(chunks[2])),
    .side_in  ({coord1, side1[DATA_W-1:0]}),
    .out_valid(v2), .quot(coord2), .rem(coord3), .side_out(side2)
  );

  assign coord[0] = side2[DATA_W-1:0];
  assign coord[1] = side2[SIDE_W-1:DATA_W];
  assign coord[2] = coord2;
  assign coord[3] = coord3;

  for (genvar d = 0; d < 4; d++) begin : g_split
    ctsim_div u_div (
      .clk, .rst, .en,
      .in_valid (v2),
      .dividend (coord[d]),
      .divisor  ((DATA_W+1)'(slen[d])),
      .side_in  ('0),
      .out_valid(v3[d]), .quot(q[d]), .rem(rm[d]), .side_out(side3[d])
    );
  end

  word_t ss [4];
  word_t is [4];
  assign ss[0] = ss0;
  assign ss[1] = ss1;
  assign ss[2] = word_t'(cd_q[2][15:0]);
  assign ss[3] = word_t'(1);
  assign is[0] = is0;
  assign is[1] = is1;
  assign is[2] = word_t'(slen[3]);
  assign is[3] = word_t'(1);

  logic  p_vld;
  word_t prod_s [4];
  word_t prod_i [4];
  logic  side_unused;

  assign side_unused = |{side3[0], side3[1], side3[2], side3[3]};

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld     <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      p_vld     <= v3[0];
      out_valid <= p_vld;
    end
    if (en) begin
      for (int d = 0; d < 4; d++) begin
        prod_s[d] <= mul_lo(q[d], ss[d]);
        prod_i[d] <= mul_lo(rm[d], is[d]);
      end
      m_tdata[31:0]  <= prod_s[0] + prod_s[1] + prod_s[2] + prod_s[3];
      m_tdata[63:32] <= prod_i[0] + prod_i[1] + prod_i[2] + prod_i[3];
    end
  end

  assign m_tvalid = out_valid;

  // lane valids of the shard split must agree; a valid request there carries zero sideband
  a_lanes_agree: assert property (@(posedge clk) disable iff (rst)
    (v3[0] == v3[1]) && (v3[0] == v3[2]) && (v3[0] == v3[3]) &&
    (!v3[0] || !side_unused))
    else $error("shard split lanes out of step");

  a_write_restarts: assert property (@(posedge clk) disable iff (rst)
    cfg_wr |=> (busy && (cnt == STEP_LOAD)))
    else $error("register write did not restart stride setup");

  a_setup_len: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> ($past(cnt) == STEP_SS0))
    else $error("stride setup ended early");

endmodule

// ===== test/tb.sv =====
// testbench for chunk_to_shard_index_map: random and directed chunk requests with a shard predictor
`timescale 1ns / 1ps
module tb;
  import ctsim_pkg::*;

  localparam logic [2:0] REG_NONE  = 3'd7;
  localparam int         IDLE_LIM  = 5000;
  localparam int         DRAIN_CYC = 160;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  chunk_to_shard_index_map DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the registers: chunk counts for dims 1..3, shard lengths for dims 0..3
  dim_t chunk_cnt [4];
  dim_t shard_len [4];

  word_t       chunk_q [$];
  logic [63:0] addr_exp_q [$];   // {slot_in_shard, shard_number}
  int          idle_pct = 36;
  bit          send_hold = 1'b0;
  bit          rx_stall_req = 1'b0;
  bit          rx_stall_done = 1'b0;
  int          rx_stall_cnt = 0;
  int          errors = 0;
  int          n_req = 0;
  int          n_res = 0;
  int          n_cfg = 0;
  int          quiet_cyc = 0;

  function automatic logic [63:0] shard_of_chunk(word_t c);
    logic [63:0] cstr [4], sstr [4], istr [4], coord [4];
    logic [63:0] cnt, len, shard, slot;
    cstr[3] = 1; sstr[3] = 1; istr[3] = 1;
    for (int i = 3; i > 0; i--) begin
      cnt = chunk_cnt[i];
      len = shard_len[i];
      cstr[i-1] = cstr[i] * cnt;
      sstr[i-1] = sstr[i] * ((cnt + len - 1) / len);
      istr[i-1] = istr[i] * len;
    end
    coord[0] = c / cstr[0];
    for (int i = 1; i < 4; i++) coord[i] = (c % cstr[i-1]) / cstr[i];
    shard = 0;
    slot = 0;
    for (int i = 0; i < 4; i++) begin
      len = shard_len[i];
      shard += (coord[i] / len) * sstr[i];
      slot += (coord[i] % len) * istr[i];
    end
    return {slot[31:0], shard[31:0]};
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %h want %h (result %0d)", what, got, want, n_res);
  endtask

  task automatic add_chunk(word_t c);
    chunk_q = {chunk_q, c};
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) begin
        addr_exp_q = {addr_exp_q, shard_of_chunk(s_tdata)};
        n_req++;
      end
      if (chunk_q.size() > 0 && !send_hold && $urandom_range(99) >= idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata <= chunk_q.pop_front();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (rx_stall_req && !rx_stall_done) begin
      m_tready <= 1'b0;
      rx_stall_cnt <= rx_stall_cnt + 1;
      if (rx_stall_cnt == 400) rx_stall_done <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    logic [63:0] want;
    if (!rst && m_tvalid && m_tready) begin
      n_res++;
      if (addr_exp_q.size() == 0) begin
        report("unexpected result", m_tdata[31:0], 32'h0);
      end else begin
        want = addr_exp_q.pop_front();
        if (m_tdata[31:0] !== want[31:0]) report("shard_number", m_tdata[31:0], want[31:0]);
        if (m_tdata[63:32] !== want[63:32]) report("slot_in_shard", m_tdata[63:32], want[63:32]);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
      quiet_cyc <= 0;
    end else begin
      quiet_cyc <= quiet_cyc + 1;
      if (quiet_cyc == IDLE_LIM) begin
        $display("timeout with %0d results outstanding", addr_exp_q.size());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic wait_idle();
    @(posedge clk);
    while (chunk_q.size() > 0 || s_tvalid || addr_exp_q.size() > 0) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00}); pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    n_cfg++;
    // zero writes and unused addresses leave the registers alone
    if (val[15:0] != 0) begin
      if (idx <= REG_CHUNKS_DIM3) chunk_cnt[2'(idx + 3'd1)] = val[15:0];
      else if (idx <= REG_SHARD_DIM3) shard_len[2'(idx - REG_SHARD_DIM0)] = val[15:0];
    end
  endtask

  task automatic set_geometry(dim_t c1, dim_t c2, dim_t c3,
                              dim_t l0, dim_t l1, dim_t l2, dim_t l3);
    reg_write(REG_CHUNKS_DIM1, 32'(c1));
    reg_write(REG_CHUNKS_DIM2, 32'(c2));
    reg_write(REG_CHUNKS_DIM3, 32'(c3));
    reg_write(REG_SHARD_DIM0, 32'(l0));
    reg_write(REG_SHARD_DIM1, 32'(l1));
    reg_write(REG_SHARD_DIM2, 32'(l2));
    reg_write(REG_SHARD_DIM3, 32'(l3));
  endtask

  function automatic dim_t pick_dim();
    int r;
    r = $urandom_range(99);
    if (r < 70) return dim_t'($urandom_range(1, 12));
    if (r < 80) return 16'hFFFF;
    if (r < 85) return 16'd1;
    return dim_t'($urandom_range(1, 65535));
  endfunction

  // mostly chunks inside a small array, some anywhere in the 32-bit range
  task automatic queue_chunks(int n);
    logic [63:0] total;
    total = 64'(chunk_cnt[1]) * chunk_cnt[2] * chunk_cnt[3] * $urandom_range(1, 8);
    repeat (n) begin
      if ($urandom_range(9) < 7 && total < 64'h1_0000_0000)
        add_chunk(word_t'($urandom % total));
      else
        add_chunk($urandom);
    end
  endtask

  initial begin
    for (int i = 0; i < 4; i++) begin
      chunk_cnt[i] = 1;
      shard_len[i] = 1;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset geometry and field extremes
    add_chunk(32'h0);
    add_chunk(32'hFFFF_FFFF);
    add_chunk(32'h1);
    wait_idle();

    // small lattice, chunks inside and beyond it
    set_geometry(3, 4, 5, 2, 3, 2, 4);
    add_chunk(32'h0);
    add_chunk(32'd59);
    add_chunk(32'd60);
    add_chunk(32'd119);
    add_chunk(32'd1000);
    add_chunk(32'hFFFF_FFFF);
    add_chunk(32'h8000_0000);
    wait_idle();

    // zero writes and an unused address change nothing
    reg_write(REG_CHUNKS_DIM1, 32'h0);
    reg_write(REG_SHARD_DIM2, 32'hFFFF_0000);
    reg_write(REG_NONE, 32'h1234);
    add_chunk(32'd77);
    add_chunk(32'd23);
    wait_idle();

    // widest lattice: results wrap
    set_geometry(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_chunk(32'hFFFF_FFFF);
    add_chunk(32'h0);
    add_chunk(32'h0001_0000);
    wait_idle();
    set_geometry(16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1, 1, 1);
    add_chunk(32'hFFFF_FFFF);
    add_chunk(32'hFEDC_BA98);
    wait_idle();

    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 11) set_geometry(1, 1, 1, 1, 1, 1, 1);
      else set_geometry(pick_dim(), pick_dim(), pick_dim(),
                        pick_dim(), pick_dim(), pick_dim(), pick_dim());
      idle_pct = (ph == 4) ? 0 : 36;
      if (ph == 2) rx_stall_req = 1'b1;
      // the hold-off phase offers more requests than the pipeline can hold
      queue_chunks((ph == 2) ? 320 : 80);
      if (ph == 6) begin
        // sender pause until the pipeline has drained
        wait (chunk_q.size() < 50);
        send_hold = 1'b1;
        while (s_tvalid || addr_exp_q.size() > 0) @(posedge clk);
        send_hold = 1'b0;
      end
      wait_idle();
    end

    repeat (DRAIN_CYC) @(posedge clk);
    $display("%0d chunk requests, %0d results, %0d register writes", n_req, n_res, n_cfg);
    $display("geometries from all ones to all 65535, with stalls and a long receiver hold");
    if (errors == 0 && addr_exp_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
